// ===== design/json_string_unescape_top_defines.svh =====
// Assertion macros shared by the JSON string unescaper.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef JSON_STRING_UNESCAPE_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("jsu: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("jsu: next-cycle check failed");

`endif

// ===== design/jsu_pkg.sv =====
// Types and constants for the JSON string unescaper.
// No dependencies; imported by jsu_front, jsu_back and the top level.
`default_nettype none

package jsu_pkg;

    // Byte codes the parser looks for
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_L   = 8'h6C;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    // Control codes produced by escapes
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;

    typedef enum logic [2:0] {
        CLS_QUOTE,
        CLS_BSLASH,
        CLS_LET_N,
        CLS_LET_U,
        CLS_LET_L,
        CLS_OTHER
    } t_cls;

    // One classified input byte
    typedef struct packed {
        logic [7:0] raw;
        t_cls       cls;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       esc_ok;
        logic [7:0] esc_char;
    } t_token;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_NULL = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] char_value;
        t_kind      kind;
    } t_result;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_NU   = 4'd1,
        PH_NL1  = 4'd2,
        PH_NL2  = 4'd3,
        PH_STR  = 4'd4,
        PH_ESC  = 4'd5,
        PH_HEX1 = 4'd6,
        PH_HEX2 = 4'd7,
        PH_HEX3 = 4'd8,
        PH_HEX4 = 4'd9
    } t_phase;

    // Handshake and status between the parser and its queues
    typedef struct packed {
        logic   tok_pop;
        logic   res_push;
        t_phase phase;
    } t_back_status;

endpackage

`default_nettype wire

// ===== design/jsu_fifo.sv =====
// Small register-based queue used between front, back and result port.
// No package dependencies.
`default_nettype none

module jsu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/jsu_front.sv =====
// Byte classifier: tags each incoming byte for the parser.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front (
    input  wire logic  [7:0] i_byte,
    output jsu_pkg::t_token o_tok
);
    import jsu_pkg::*;

    always_comb begin
        o_tok          = '0;
        o_tok.raw      = i_byte;
        o_tok.cls      = CLS_OTHER;
        o_tok.hex_ok   = 1'b0;
        o_tok.hex_val  = '0;
        o_tok.esc_ok   = 1'b0;
        o_tok.esc_char = '0;

        unique case (i_byte)
            CH_QUOTE:  o_tok.cls = CLS_QUOTE;
            CH_BSLASH: o_tok.cls = CLS_BSLASH;
            CH_LOW_N:  o_tok.cls = CLS_LET_N;
            CH_LOW_U:  o_tok.cls = CLS_LET_U;
            CH_LOW_L:  o_tok.cls = CLS_LET_L;
            default:   o_tok.cls = CLS_OTHER;
        endcase

        // Escape letters that map straight to one character
        unique case (i_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                o_tok.esc_ok   = 1'b1;
                o_tok.esc_char = i_byte;
            end
            CH_LOW_B: begin
                o_tok.esc_ok   = 1'b1;
                o_tok.esc_char = CODE_BS;
            end
            CH_LOW_F: begin
                o_tok.esc_ok   = 1'b1;
                o_tok.esc_char = CODE_FF;
            end
            CH_LOW_N: begin
                o_tok.esc_ok   = 1'b1;
                o_tok.esc_char = CODE_LF;
            end
            CH_LOW_R: begin
                o_tok.esc_ok   = 1'b1;
                o_tok.esc_char = CODE_CR;
            end
            CH_LOW_T: begin
                o_tok.esc_ok   = 1'b1;
                o_tok.esc_char = CODE_TAB;
            end
            default: begin
                o_tok.esc_ok   = 1'b0;
                o_tok.esc_char = '0;
            end
        endcase

        priority if (i_byte >= CH_DIGIT_0 && i_byte <= CH_DIGIT_9) begin
            o_tok.hex_ok  = 1'b1;
            o_tok.hex_val = i_byte[3:0];
        end else if (i_byte >= CH_UPPER_A && i_byte <= CH_UPPER_F) begin
            o_tok.hex_ok  = 1'b1;
            o_tok.hex_val = 4'(i_byte - CH_UPPER_A + 8'd10);
        end else if (i_byte >= CH_LOWER_A && i_byte <= CH_LOWER_F) begin
            o_tok.hex_ok  = 1'b1;
            o_tok.hex_val = 4'(i_byte - CH_LOWER_A + 8'd10);
        end else begin
            o_tok.hex_ok  = 1'b0;
            o_tok.hex_val = '0;
        end
    end

endmodule

`default_nettype wire

// ===== design/jsu_back.sv =====
// Parser state machine: consumes classified bytes, produces results.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire jsu_pkg::t_token        i_tok,
    input  wire logic                   i_tok_valid,
    input  wire logic                   i_res_full,
    output jsu_pkg::t_result            o_res,
    output jsu_pkg::t_back_status       o_status
);
    import jsu_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_hex, n_hex;
    logic       take;
    logic       res_hit;
    logic [7:0] hex_byte;

    // Only the low byte of the code survives, so keep just the previous digit
    assign hex_byte = {r_hex, i_tok.hex_val};
    assign take     = i_tok_valid && !i_res_full;

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        if (take) begin
            unique case (r_phase)
                PH_NU:  n_phase = (i_tok.cls == CLS_LET_U) ? PH_NL1 : PH_IDLE;
                PH_NL1: n_phase = (i_tok.cls == CLS_LET_L) ? PH_NL2 : PH_IDLE;
                PH_NL2: n_phase = PH_IDLE;
                PH_STR: begin
                    if (i_tok.cls == CLS_QUOTE) begin
                        n_phase = PH_IDLE;
                    end else if (i_tok.cls == CLS_BSLASH) begin
                        n_phase = PH_ESC;
                    end
                end
                PH_ESC: begin
                    if (i_tok.cls == CLS_LET_U) begin
                        n_phase = PH_HEX1;
                    end else if (i_tok.esc_ok) begin
                        n_phase = PH_STR;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_HEX1: n_phase = i_tok.hex_ok ? PH_HEX2 : PH_IDLE;
                PH_HEX2: n_phase = i_tok.hex_ok ? PH_HEX3 : PH_IDLE;
                PH_HEX3: n_phase = i_tok.hex_ok ? PH_HEX4 : PH_IDLE;
                PH_HEX4: n_phase = i_tok.hex_ok ? PH_STR : PH_IDLE;
                default: begin
                    // idle, and any code outside the encoding
                    if (i_tok.cls == CLS_LET_N) begin
                        n_phase = PH_NU;
                    end else if (i_tok.cls == CLS_QUOTE) begin
                        n_phase = PH_STR;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            endcase
            if (r_phase == PH_HEX1 || r_phase == PH_HEX2 ||
                r_phase == PH_HEX3 || r_phase == PH_HEX4) begin
                n_hex = i_tok.hex_val;
            end
        end
    end

    always_comb begin
        res_hit          = 1'b0;
        o_res.char_value = '0;
        o_res.kind       = KIND_ERR;
        unique case (r_phase)
            PH_NU:  res_hit = (i_tok.cls != CLS_LET_U);
            PH_NL1: res_hit = (i_tok.cls != CLS_LET_L);
            PH_NL2: begin
                res_hit    = 1'b1;
                o_res.kind = (i_tok.cls == CLS_LET_L) ? KIND_NULL : KIND_ERR;
            end
            PH_STR: begin
                if (i_tok.cls == CLS_QUOTE) begin
                    res_hit    = 1'b1;
                    o_res.kind = KIND_END;
                end else if (i_tok.cls != CLS_BSLASH) begin
                    res_hit          = 1'b1;
                    o_res.kind       = KIND_CHAR;
                    o_res.char_value = i_tok.raw;
                end
            end
            PH_ESC: begin
                if (i_tok.cls != CLS_LET_U) begin
                    res_hit = 1'b1;
                    if (i_tok.esc_ok) begin
                        o_res.kind       = KIND_CHAR;
                        o_res.char_value = i_tok.esc_char;
                    end
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3: res_hit = !i_tok.hex_ok;
            PH_HEX4: begin
                res_hit = 1'b1;
                if (i_tok.hex_ok) begin
                    o_res.kind       = KIND_CHAR;
                    o_res.char_value = hex_byte;
                end
            end
            default: res_hit = (i_tok.cls != CLS_LET_N) && (i_tok.cls != CLS_QUOTE);
        endcase
        o_status.tok_pop  = take;
        o_status.res_push = take && res_hit;
        o_status.phase    = r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hex   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
        end
    end

endmodule

`default_nettype wire

// ===== design/json_string_unescape_top.sv =====
// Top level of the JSON string unescaper: classifier, byte queue, parser, result queue.
// Depends on jsu_pkg, jsu_fifo, jsu_front, jsu_back and the assertion macro header.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------
//  bytes    | in        | push / full      | i_in_byte
//  results  | out       | pop / empty      | o_char_value, o_result_kind
//
// One byte per cycle sustained, set by the single-step parser state machine, while the
// result queue has room. A byte is registered in the byte queue before the parser takes
// it; its result is registered in the result queue before it reaches the result ports.
// Reset is synchronous and empties both queues; the parser returns to idle.
// When the result queue fills, the parser stalls and the byte queue absorbs up to
// IN_DEPTH bytes before full rises.
`default_nettype none
`include "json_string_unescape_top_defines.svh"

module json_string_unescape_top #(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       pop,
    output logic            empty,
    output logic      [7:0] o_char_value,
    output logic      [1:0] o_result_kind
);
    import jsu_pkg::*;

    t_token       front_tok;
    t_token       mid_tok;
    logic         mid_empty;
    t_result      back_res;
    t_back_status back_st;
    logic         res_full;
    t_result      out_res;

    jsu_front u_front (
        .i_byte (i_in_byte),
        .o_tok  (front_tok)
    );

    jsu_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (IN_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_tok),
        .o_full  (full),
        .i_pop   (back_st.tok_pop),
        .o_data  (mid_tok),
        .o_empty (mid_empty)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (mid_tok),
        .i_tok_valid (!mid_empty),
        .i_res_full  (res_full),
        .o_res       (back_res),
        .o_status    (back_st)
    );

    jsu_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_st.res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_char_value  = out_res.char_value;
    assign o_result_kind = out_res.kind;

    `JSU_ASSERT_NOW(a_push_has_room, back_st.res_push, !res_full && !mid_empty)
    `JSU_ASSERT_NOW(a_nonchar_zero, !empty && o_result_kind != KIND_CHAR, o_char_value == 8'd0)
    `JSU_ASSERT_NEXT(a_idle_after_end, back_st.res_push && back_res.kind != KIND_CHAR,
                     back_st.phase == PH_IDLE)

endmodule

`default_nettype wire
